// ===== rtl/speed_weighted_turn_scheduler_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the scheduler RTL
// ---------------------------------------------------------------------------
`ifndef SPEED_WEIGHTED_TURN_SCHEDULER_TOP_MACROS_SVH
`define SPEED_WEIGHTED_TURN_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SWTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, disabled during reset
`define SWTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== rtl/swts_pkg.sv =====
// ---------------------------------------------------------------------------
// swts_pkg
// Shared constants and types of the turn scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swts_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int TIME_W  = 48;
    localparam int SCALE_W = 16;
    localparam int SPEED_W = 10;
    localparam int SLOT_W  = 4;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd100;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REG   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_KILL  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef logic [TIME_W-1:0] t_time;

    localparam t_time TIME_NEVER = '1;

endpackage

// ===== rtl/speed_weighted_turn_scheduler_top.sv =====
// ---------------------------------------------------------------------------
// speed_weighted_turn_scheduler_top
// Stride scheduler: entries with a turn time and a stride in one RAM.
// ---------------------------------------------------------------------------
// Requests enter on the s_ stream: tuser carries the command, tdata the
// speed and the slot. Each request yields one result on the m_ stream:
// tuser carries the status, tdata the slot and the turn time.
// time_scale is written through i_cfg_we / i_cfg_wdata; the user must write
// it only while idle, the block does not enforce this. One request is worked
// at a time; s_tready is high only when the sequencer is idle.
// Clear and kill go from idle straight to S_FIN, which loads the result.
// Register runs the bit-serial divider in S_DIV, then writes the entry in
// S_REGW; a full table or speed zero skips the divider.
// Next turn makes two RAM sweeps, one read a cycle, in S_SCAN1 and S_SCAN2,
// to find the least live time and to drop dead entries ahead of it, then
// one write-back of the advanced time in S_WB; with no live entry the
// write-back is skipped.
// Reset empties the table and sets time_scale to 100; RAM contents are not
// cleared, unoccupied slots are ignored.
// A stalled m_ side holds the result; the block finishes the next request
// and waits with it until the output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "speed_weighted_turn_scheduler_top_macros.svh"

module speed_weighted_turn_scheduler_top #(
    parameter int ENTRIES       = swts_pkg::ENTRIES_DEF,
    parameter int FRACTION_BITS = swts_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [swts_pkg::SCALE_W-1:0] i_cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [9:0] speed, [13:10] slot_id, [15:14] zero
    input  logic [15:0]                  s_tdata,
    // [1:0] cmd
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [3:0] chosen_slot, [51:4] turn_time, [55:52] zero
    output logic [55:0]                  m_tdata,
    // [1:0] status
    output logic [1:0]                   m_tuser
);

    import swts_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int NUM_W = SCALE_W + FRACTION_BITS;
    localparam int MEM_W = 2 * TIME_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_REGW  = 3'd2;
    localparam logic [2:0] S_SCAN1 = 3'd3;
    localparam logic [2:0] S_SCAN2 = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]         r_state;
    logic [SCALE_W-1:0] r_scale;
    logic [ENTRIES-1:0] r_occ;
    logic [ENTRIES-1:0] r_alive;

    logic [CNT_W-1:0]   r_cnt;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_best_idx;
    t_time              r_best_t;
    t_time              r_best_s;
    logic [IDX_W-1:0]   r_slot;
    t_time              r_stride;

    logic [STAT_W-1:0]  r_res_st;
    logic [SLOT_W-1:0]  r_res_slot;
    t_time              r_res_time;

    logic               r_m_valid;
    logic [STAT_W-1:0]  r_m_st;
    logic [SLOT_W-1:0]  r_m_slot;
    t_time              r_m_time;

    logic [CMD_W-1:0]   w_cmd;
    logic [SPEED_W-1:0] w_speed;
    logic [SLOT_W-1:0]  w_slot_id;
    logic               w_accept;
    logic               w_free_ok;
    logic [IDX_W-1:0]   w_free_idx;
    logic               w_kill_ok;
    logic [IDX_W-1:0]   w_kill_idx;
    logic               w_div_start;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quo;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [MEM_W-1:0]   w_wdata;
    logic [MEM_W-1:0]   w_rd;
    t_time              w_rd_t;
    t_time              w_rd_s;
    logic [TIME_W:0]    w_sum;
    t_time              w_next_t;
    logic               w_out_free;
    logic               w_scan_end;
    logic               w_live_hit;
    logic               w_drop_hit;

    assign w_cmd     = s_tuser;
    assign w_speed   = s_tdata[9:0];
    assign w_slot_id = s_tdata[13:10];
    assign s_tready  = (r_state == S_IDLE);
    assign w_accept  = s_tvalid && s_tready;

    // lowest free slot
    always_comb begin
        w_free_ok  = 1'b0;
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                w_free_ok  = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    assign w_kill_idx = IDX_W'(w_slot_id);
    assign w_kill_ok  = (9'(w_slot_id) < 9'(ENTRIES)) && r_occ[w_kill_idx];

    assign w_div_start = w_accept && (w_cmd == CMD_REG) && w_free_ok
                         && (w_speed != '0);

    swts_div #(
        .NUM_W (NUM_W),
        .DEN_W (SPEED_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (NUM_W'(r_scale) << FRACTION_BITS),
        .i_divisor  (w_speed),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_sum    = {1'b0, r_best_t} + {1'b0, r_best_s};
    assign w_next_t = w_sum[TIME_W] ? TIME_NEVER : w_sum[TIME_W-1:0];

    assign w_we    = (r_state == S_REGW) || (r_state == S_WB);
    assign w_waddr = (r_state == S_WB) ? r_best_idx : r_slot;
    assign w_wdata = (r_state == S_WB) ? {r_best_s, w_next_t} : {r_stride, r_stride};

    swts_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (w_rd)
    );

    assign w_rd_t = w_rd[TIME_W-1:0];
    assign w_rd_s = w_rd[MEM_W-1:TIME_W];

    assign w_scan_end = !r_pend && (r_cnt == CNT_W'(ENTRIES));
    assign w_live_hit = r_pend && r_occ[r_pend_idx] && r_alive[r_pend_idx]
                        && (!r_found || (w_rd_t < r_best_t));
    assign w_drop_hit = r_pend && r_occ[r_pend_idx] && !r_alive[r_pend_idx]
                        && (!r_found || (w_rd_t < r_best_t)
                            || ((w_rd_t == r_best_t) && (r_pend_idx < r_best_idx)));

    assign w_out_free = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_scale   <= SCALE_RESET;
            r_occ     <= '0;
            r_alive   <= '0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (r_m_valid && m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt   <= '0;
                    r_pend  <= 1'b0;
                    r_found <= 1'b0;
                    if (w_accept) begin
                        case (w_cmd)
                            CMD_CLEAR: begin
                                r_occ   <= '0;
                                r_alive <= '0;
                                r_state <= S_FIN;
                            end
                            CMD_REG: begin
                                if (!w_free_ok) begin
                                    r_state <= S_FIN;
                                end else if (w_speed == '0) begin
                                    r_state <= S_REGW;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            CMD_NEXT: begin
                                r_state <= S_SCAN1;
                            end
                            default: begin
                                if (w_kill_ok) begin
                                    r_alive[w_kill_idx] <= 1'b0;
                                end
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_REGW;
                    end
                end
                S_REGW: begin
                    r_occ[r_slot]   <= 1'b1;
                    r_alive[r_slot] <= 1'b1;
                    r_state         <= S_FIN;
                end
                S_SCAN1, S_SCAN2: begin
                    if (r_cnt < CNT_W'(ENTRIES)) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_state == S_SCAN1) begin
                        if (w_live_hit) begin
                            r_found <= 1'b1;
                        end
                        if (w_scan_end) begin
                            r_cnt   <= '0;
                            r_state <= S_SCAN2;
                        end
                    end else begin
                        if (w_drop_hit) begin
                            r_occ[r_pend_idx] <= 1'b0;
                        end
                        if (w_scan_end) begin
                            r_state <= r_found ? S_WB : S_FIN;
                        end
                    end
                end
                S_WB: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: result, best entry, stride
    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_cnt[IDX_W-1:0];
        if (w_accept) begin
            r_slot     <= w_free_idx;
            r_stride   <= TIME_NEVER;
            r_res_st   <= ST_OK;
            r_res_slot <= '0;
            r_res_time <= '0;
            case (w_cmd)
                CMD_CLEAR: begin
                    r_res_st <= ST_OK;
                end
                CMD_REG: begin
                    if (!w_free_ok) begin
                        r_res_st <= ST_FULL;
                    end
                end
                CMD_NEXT: begin
                    r_res_st <= ST_NONE;
                end
                default: begin
                    r_res_st   <= w_kill_ok ? ST_OK : ST_NONE;
                    r_res_slot <= w_slot_id;
                end
            endcase
        end
        if (r_state == S_DIV && w_div_done) begin
            r_stride <= TIME_W'(w_quo);
        end
        if (r_state == S_REGW) begin
            r_res_slot <= SLOT_W'(r_slot);
            r_res_time <= r_stride;
        end
        if (r_state == S_SCAN1 && w_live_hit) begin
            r_best_idx <= r_pend_idx;
            r_best_t   <= w_rd_t;
            r_best_s   <= w_rd_s;
        end
        if (r_state == S_WB) begin
            r_res_st   <= ST_OK;
            r_res_slot <= SLOT_W'(r_best_idx);
            r_res_time <= r_best_t;
        end
        if (r_state == S_FIN && w_out_free) begin
            r_m_st   <= r_res_st;
            r_m_slot <= r_res_slot;
            r_m_time <= r_res_time;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_st;
    assign m_tdata  = {4'b0000, r_m_time, r_m_slot};

    `SWTS_ASSERT_IMP(a_alive_occ, i_clk, i_rst_n, 1'b1, ((r_alive & ~r_occ) == '0))
    `SWTS_ASSERT_IMP(a_div_in_div, i_clk, i_rst_n, w_div_done, (r_state == S_DIV))
    `SWTS_ASSERT_NXT(a_fin_load, i_clk, i_rst_n, (r_state == S_FIN) && w_out_free,
                     m_tvalid && (r_state == S_IDLE))
    `SWTS_ASSERT_NXT(a_next_scan, i_clk, i_rst_n, w_accept && (w_cmd == CMD_NEXT),
                     (r_state == S_SCAN1) && !r_pend && !r_found)

endmodule

// ===== rtl/swts_ram.sv =====
// ---------------------------------------------------------------------------
// swts_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swts_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/swts_div.sv =====
// ---------------------------------------------------------------------------
// swts_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swts_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sim/speed_weighted_turn_scheduler_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// speed_weighted_turn_scheduler_top_test
// Self-checking bench for the stride turn scheduler. A short table of
// directed requests covers the empty table, dead entries, never entries and
// the full table. Random request sequences follow under several time_scale
// settings. Each one fills the table, plays turns, kills and clears. Every
// accepted request is run through a local scheduler model, and each result
// is compared field by field. Both stream sides idle at random, and the
// result side holds off once for a long stretch.
// ---------------------------------------------------------------------------

module speed_weighted_turn_scheduler_top_test;
    import swts_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int SLOTS        = ENTRIES_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 230;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        t_time             turn_time;
    } turn_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SPEED_W-1:0] speed;
        logic [SLOT_W-1:0]  slot;
        logic [4:0]         reps;
        logic               typed;
        turn_result_t       result;
    } request_row_t;

    localparam int DIRECTED_ROWS = 15;
    localparam request_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_NEXT,  10'd0,    4'd0,  5'd1,  1'b1, '{ST_NONE, 4'd0,  48'd0}},
        '{CMD_KILL,  10'd0,    4'd15, 5'd1,  1'b1, '{ST_NONE, 4'd15, 48'd0}},
        '{CMD_REG,   10'd1,    4'd0,  5'd1,  1'b1, '{ST_OK,   4'd0,  48'd6553600}},
        '{CMD_REG,   10'd1023, 4'd0,  5'd1,  1'b0, '0},
        '{CMD_REG,   10'd0,    4'd15, 5'd1,  1'b1, '{ST_OK,   4'd2,  TIME_NEVER}},
        '{CMD_KILL,  10'd1023, 4'd1,  5'd1,  1'b1, '{ST_OK,   4'd1,  48'd0}},
        '{CMD_NEXT,  10'd0,    4'd0,  5'd1,  1'b0, '0},
        '{CMD_KILL,  10'd0,    4'd0,  5'd1,  1'b1, '{ST_OK,   4'd0,  48'd0}},
        '{CMD_NEXT,  10'd0,    4'd0,  5'd1,  1'b1, '{ST_OK,   4'd2,  TIME_NEVER}},
        '{CMD_KILL,  10'd0,    4'd2,  5'd1,  1'b1, '{ST_OK,   4'd2,  48'd0}},
        '{CMD_NEXT,  10'd0,    4'd0,  5'd1,  1'b1, '{ST_NONE, 4'd0,  48'd0}},
        '{CMD_REG,   10'd512,  4'd0,  5'd16, 1'b0, '0},
        '{CMD_REG,   10'd1,    4'd15, 5'd1,  1'b1, '{ST_FULL, 4'd0,  48'd0}},
        '{CMD_NEXT,  10'd0,    4'd0,  5'd1,  1'b0, '0},
        '{CMD_CLEAR, 10'd1023, 4'd15, 5'd1,  1'b1, '{ST_OK,   4'd0,  48'd0}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [SCALE_W-1:0]   i_cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [55:0]          m_tdata;
    logic [1:0]           m_tuser;

    t_time                slot_time [SLOTS];
    t_time                slot_stride [SLOTS];
    logic [SLOTS-1:0]     slot_used;
    logic [SLOTS-1:0]     slot_live;
    logic [SCALE_W-1:0]   scale_reg;

    turn_result_t         expected_turns [$];
    turn_result_t         want;
    int                   fault_count = 0;
    int                   idle_cycles = 0;
    bit                   hold_request = 1'b0;

    speed_weighted_turn_scheduler_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic schedule_turn(input logic [CMD_W-1:0] cmd, input logic [SPEED_W-1:0] speed,
                                 input logic [SLOT_W-1:0] slot, output turn_result_t res);
        int    free_slot;
        int    best;
        t_time advanced;
        res = '0;
        case (cmd)
            CMD_CLEAR: begin
                slot_used = '0;
                slot_live = '0;
            end
            CMD_REG: begin
                free_slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_used[i]) free_slot = i;
                if (free_slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    slot_stride[free_slot] = (speed == '0) ? TIME_NEVER
                        : (t_time'(scale_reg) << FRAC) / t_time'(speed);
                    slot_time[free_slot] = slot_stride[free_slot];
                    slot_used[free_slot] = 1'b1;
                    slot_live[free_slot] = 1'b1;
                    res.status    = ST_OK;
                    res.slot      = SLOT_W'(free_slot);
                    res.turn_time = slot_stride[free_slot];
                end
            end
            CMD_NEXT: begin
                // drop dead entries holding the least time until a live one leads
                forever begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_used[i] && (best < 0 || slot_time[i] < slot_time[best]))
                            best = i;
                    if (best < 0 || slot_live[best]) break;
                    slot_used[best] = 1'b0;
                end
                if (best < 0) begin
                    res.status = ST_NONE;
                end else begin
                    res.status    = ST_OK;
                    res.slot      = SLOT_W'(best);
                    res.turn_time = slot_time[best];
                    advanced = slot_time[best] + slot_stride[best];
                    if (advanced < slot_time[best]) advanced = TIME_NEVER;
                    slot_time[best] = advanced;
                end
            end
            default: begin
                res.slot = slot;
                if (slot_used[slot]) begin
                    slot_live[slot] = 1'b0;
                    res.status = ST_OK;
                end else begin
                    res.status = ST_NONE;
                end
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 70);
    endfunction

    task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [SPEED_W-1:0] speed,
                                input logic [SLOT_W-1:0] slot, input int gap,
                                input logic typed, input turn_result_t typed_res);
        turn_result_t predicted;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, slot, speed};
        do @(negedge i_clk); while (!s_tready);
        @(posedge i_clk);
        schedule_turn(cmd, speed, slot, predicted);
        expected_turns.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_turns.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_phase(input int phase);
        int                 sent;
        int                 seq_len;
        int                 mode;
        int                 r;
        int                 probe;
        bit                 gap_free;
        logic [CMD_W-1:0]   cmd;
        logic [SPEED_W-1:0] speed;
        logic [SLOT_W-1:0]  slot;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            // mode: fill the table, play turns, or plain noise
            mode     = $urandom_range(0, 9);
            seq_len  = $urandom_range(8, 40);
            gap_free = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < seq_len && sent < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 5) speed = '0;
                else if (r < 25) speed = SPEED_W'($urandom_range(1, 8));
                else if (r < 40) speed = SPEED_W'($urandom_range(1000, 1023));
                else speed = SPEED_W'($urandom_range(1, 1023));
                slot = SLOT_W'($urandom_range(0, SLOTS - 1));
                r = $urandom_range(0, 99);
                if (mode == 9) cmd = CMD_W'($urandom);
                else if (mode < 3) cmd = (r < 85) ? CMD_REG : (r < 95) ? CMD_NEXT : CMD_KILL;
                else cmd = (r < 3) ? CMD_CLEAR : (r < 18) ? CMD_REG
                         : (r < 35) ? CMD_KILL : CMD_NEXT;
                if (cmd == CMD_KILL && mode != 9 && $urandom_range(0, 4) != 0) begin
                    probe = $urandom_range(0, SLOTS - 1);
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (slot_used[(probe + i) % SLOTS]) slot = SLOT_W'((probe + i) % SLOTS);
                end
                if (phase == 1 && sent == 60) hold_request = 1'b1;
                push_request(cmd, speed, slot, gap_free ? 0 : pick_gap(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 100)
                                                : $urandom_range(1, 6)) @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                int stall;
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_turns.size() == 0) begin
                    $display("%0t: result with no request pending: status %0d slot %0d time %0h",
                             $time, m_tuser, m_tdata[3:0], m_tdata[51:4]);
                    fault_count++;
                end else begin
                    want = expected_turns.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        fault_count++;
                    end
                    if (m_tdata[3:0] !== want.slot) begin
                        $display("%0t: chosen_slot expected %0d actual %0d",
                                 $time, want.slot, m_tdata[3:0]);
                        fault_count++;
                    end
                    if (m_tdata[51:4] !== want.turn_time) begin
                        $display("%0t: turn_time expected %0h actual %0h",
                                 $time, want.turn_time, m_tdata[51:4]);
                        fault_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        logic [SCALE_W-1:0] new_scale;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_CLEAR;
        scale_reg   = SCALE_RESET;
        slot_used   = '0;
        slot_live   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            repeat (DIRECTED[r].reps)
                push_request(DIRECTED[r].cmd, DIRECTED[r].speed, DIRECTED[r].slot,
                             pick_gap(), DIRECTED[r].typed, DIRECTED[r].result);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       new_scale = 16'd1;
                1:       new_scale = 16'hFFFF;
                2:       new_scale = 16'd0;
                4:       new_scale = SCALE_RESET;
                default: new_scale = SCALE_W'($urandom_range(2, 65534));
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= new_scale;
            @(posedge i_clk);
            i_cfg_we  <= 1'b0;
            scale_reg = new_scale;
            run_phase(p);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && expected_turns.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/swts_pkg.sv
rtl/swts_ram.sv
rtl/swts_div.sv
rtl/speed_weighted_turn_scheduler_top.sv
sim/speed_weighted_turn_scheduler_top_test.sv
